// ----- hw/rtl/fvrp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flash verify request parser package
// Shared widths and the result type for one parsed item.
// ----------------------------------------------------------------------------
package fvrp_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 32;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 8;

    localparam logic KIND_PAGE   = 1'b0;
    localparam logic KIND_CONFIG = 1'b1;

    typedef struct packed {
        logic              accepted;
        logic              record_valid;
        logic              record_kind;
        logic [ADDR_W-1:0] record_address;
        logic [VAL_W-1:0]  record_value;
        logic              request_done;
    } fvrp_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/flash_verify_request_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Results are registered in the output entry, or in the skid entry while it is stalled.
// Throughput: one item per cycle; a two-entry output buffer keeps input flowing.
// The input stalls only when both output entries hold results not yet taken.
// Reset: asynchronous, active low; the parser returns to the page count phase
// and the output buffer is emptied.
// ----------------------------------------------------------------------------
// Flash verify request parser
// Parses a byte stream of page checksum and config word records.
// ----------------------------------------------------------------------------
module flash_verify_request_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [fvrp_pkg::BYTE_W-1:0] in_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             accepted,
    output logic                             record_valid,
    output logic                             record_kind,
    output logic [fvrp_pkg::ADDR_W-1:0]      record_address,
    output logic [fvrp_pkg::VAL_W-1:0]       record_value,
    output logic                             request_done
);
    import fvrp_pkg::*;

    fvrp_result_t result;
    fvrp_result_t out_data_reg;
    fvrp_result_t skid_data_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         in_fire;
    logic         out_stalled;

    assign in_ready    = !skid_valid_reg;
    assign in_fire     = in_valid && in_ready;
    assign out_stalled = out_valid_reg && !out_ready;

    fvrp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_fire),
        .in_byte (in_byte),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_ready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_stalled)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_stalled)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = out_data_reg.accepted;
    assign record_valid   = out_data_reg.record_valid;
    assign record_kind    = out_data_reg.record_kind;
    assign record_address = out_data_reg.record_address;
    assign record_value   = out_data_reg.record_value;
    assign request_done   = out_data_reg.request_done;

endmodule
`default_nettype wire

// ----- hw/rtl/fvrp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flash verify request parser core
// Holds the parse state and computes the result of each byte combinationally.
// ----------------------------------------------------------------------------
module fvrp_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [fvrp_pkg::BYTE_W-1:0] in_byte,
    output fvrp_pkg::fvrp_result_t          result
);
    import fvrp_pkg::*;

    typedef enum logic [2:0] {
        PH_PAGE_COUNT = 3'd0,
        PH_WORD_COUNT = 3'd1,
        PH_PAGE_ADDR  = 3'd2,
        PH_PAGE_SUM   = 3'd3,
        PH_CFG_ADDR   = 3'd4,
        PH_CFG_VAL    = 3'd5,
        PH_DONE       = 3'd6
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  pages_left_reg, pages_left_next;
    logic [CNT_W-1:0]  words_left_reg, words_left_next;
    logic [ADDR_W-1:0] address_accum_reg, address_accum_next;
    logic [VAL_W-1:0]  value_accum_reg, value_accum_next;
    logic [1:0]        byte_index_reg, byte_index_next;

    logic [ADDR_W-1:0] address_merged;
    logic [VAL_W-1:0]  value_merged;

    assign address_merged = address_accum_reg
                          | ({{(ADDR_W-BYTE_W){1'b0}}, in_byte} << {byte_index_reg, 3'b000});
    assign value_merged   = value_accum_reg
                          | ({{(VAL_W-BYTE_W){1'b0}}, in_byte} << {byte_index_reg[0], 3'b000});

    always_comb
    begin
        phase_next         = phase_reg;
        pages_left_next    = pages_left_reg;
        words_left_next    = words_left_reg;
        address_accum_next = address_accum_reg;
        value_accum_next   = value_accum_reg;
        byte_index_next    = byte_index_reg;
        result             = '0;
        result.accepted    = 1'b1;

        unique case (phase_reg)
            PH_PAGE_COUNT:
            begin
                pages_left_next = in_byte;
                phase_next      = PH_WORD_COUNT;
            end
            PH_WORD_COUNT:
            begin
                words_left_next = in_byte;
                if (pages_left_reg != '0)
                begin
                    pages_left_next    = pages_left_reg - CNT_W'(1);
                    phase_next         = PH_PAGE_ADDR;
                    address_accum_next = '0;
                    byte_index_next    = 2'd3;
                end
                else if (in_byte != '0)
                begin
                    words_left_next    = in_byte - CNT_W'(1);
                    phase_next         = PH_CFG_ADDR;
                    address_accum_next = '0;
                    byte_index_next    = 2'd3;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_PAGE_ADDR, PH_CFG_ADDR:
            begin
                address_accum_next = address_merged;
                if (byte_index_reg == 2'd0)
                begin
                    phase_next       = (phase_reg == PH_PAGE_ADDR) ? PH_PAGE_SUM : PH_CFG_VAL;
                    value_accum_next = '0;
                    byte_index_next  = 2'd1;
                end
                else
                begin
                    byte_index_next = byte_index_reg - 2'd1;
                end
            end
            PH_PAGE_SUM, PH_CFG_VAL:
            begin
                value_accum_next = value_merged;
                if (!byte_index_reg[0])
                begin
                    result.record_valid   = 1'b1;
                    result.record_kind    = (phase_reg == PH_CFG_VAL) ? KIND_CONFIG : KIND_PAGE;
                    result.record_address = address_accum_reg;
                    result.record_value   = value_merged;
                    if (phase_reg == PH_PAGE_SUM && pages_left_reg != '0)
                    begin
                        pages_left_next    = pages_left_reg - CNT_W'(1);
                        phase_next         = PH_PAGE_ADDR;
                        address_accum_next = '0;
                        byte_index_next    = 2'd3;
                    end
                    else if (words_left_reg != '0)
                    begin
                        words_left_next    = words_left_reg - CNT_W'(1);
                        phase_next         = PH_CFG_ADDR;
                        address_accum_next = '0;
                        byte_index_next    = 2'd3;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                else
                begin
                    byte_index_next = 2'd0;
                end
            end
            default:
            begin
                result.accepted = 1'b0;
            end
        endcase

        result.request_done = (phase_next == PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_PAGE_COUNT;
            pages_left_reg    <= '0;
            words_left_reg    <= '0;
            address_accum_reg <= '0;
            value_accum_reg   <= '0;
            byte_index_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            pages_left_reg    <= pages_left_next;
            words_left_reg    <= words_left_next;
            address_accum_reg <= address_accum_next;
            value_accum_reg   <= value_accum_next;
            byte_index_reg    <= byte_index_next;
        end
    end

endmodule
`default_nettype wire
